// File: rtl/core/ipv4hc_pkg.sv
package ipv4hc_pkg;

	localparam int unsigned HEADER_WORDS = 10;
	localparam logic [15:0] HEADER_BYTES = 16'(2 * HEADER_WORDS);

	localparam logic [31:0] BROADCAST_ADDR = 32'hFFFF_FFFF;
	localparam logic [31:0] OWN_ADDR_RESET = 32'hC0A8_0001;
	localparam int unsigned MORE_FRAG_BIT = 13;
	localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;
	localparam logic [15:0] SUM_ZERO = 16'h0000;

	// header word positions
	localparam logic [3:0] POS_IP_LEN = 4'd1;
	localparam logic [3:0] POS_ID = 4'd2;
	localparam logic [3:0] POS_FLAGS = 4'd3;
	localparam logic [3:0] POS_TTL = 4'd4;
	localparam logic [3:0] POS_DST_HI = 4'd8;
	localparam logic [3:0] POS_DST_LO = 4'd9;
	localparam logic [3:0] POS_MAX = 4'd15;

	typedef enum logic [1:0] {
		VERDICT_OK = 2'd0,
		VERDICT_BAD_DST = 2'd1,
		VERDICT_BAD_SUM = 2'd2,
		VERDICT_TTL_ZERO = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		ACTION_DROP = 2'd0,
		ACTION_APPEND = 2'd1,
		ACTION_DELIVER = 2'd2
	} action_t;

	typedef struct packed {
		action_t action;
		verdict_t verdict;
	} result_user_t;

	typedef struct packed {
		logic [15:0] datagram_id;
		logic [15:0] datagram_length;
		logic [15:0] payload_length;
	} result_data_t;

endpackage

// File: rtl/core/ipv4_header_check_and_reassembly.sv
// ipv4 header check and fragment length tracking
//
// s_axis: one 16-bit header word per transaction, network order, first word
// first; s_axis_tlast marks the final word of a header. every word is folded
// into a one's-complement sum and the length, id, flags, ttl and destination
// words are captured by position.
// m_axis: one result transaction per header, carrying the verdict and action
// in tuser and the payload length, datagram length and expected id in tdata.
// own_address_we/own_address_wdata write the accepted unicast destination;
// write it only while no header is in flight.
// throughput: one word per cycle, sustained while m_axis keeps up.
// the last word sits in the input register, then loads the result register
// that drives m_axis_tvalid, m_axis_tuser and m_axis_tdata.
// when m_axis_tready is low a finished result holds in the result register;
// further words are still taken until the next last word reaches the input
// register, which then waits for the result register to drain.
// reset: running length, expected id and the header accumulators clear, the
// own address returns to its reset value and no result is pending.
module ipv4_header_check_and_reassembly (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] header_word
	input  logic        s_axis_tlast,   // last_word
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [15:0] payload_length, [31:16] datagram_length,
	                                    // [47:32] datagram_id
	output logic [3:0]  m_axis_tuser,   // [1:0] verdict, [3:2] action
	input  logic        own_address_we,
	input  logic [31:0] own_address_wdata
);
	import ipv4hc_pkg::*;

	logic        valid_s1;
	logic [15:0] word_s1;
	logic        last_s1;
	logic        advance_s1;
	logic        fire_s1;

	logic [31:0] own_addr_q;
	logic [3:0]  word_idx_q;
	logic [15:0] ones_sum_q;
	logic [15:0] ip_len_q;
	logic [15:0] ident_q;
	logic [15:0] flags_q;
	logic [7:0]  ttl_q;
	logic [31:0] dst_q;
	logic [15:0] expected_id_q;
	logic [15:0] running_len_q;

	logic         m_valid_q;
	result_user_t m_user_q;
	result_data_t m_data_q;

	logic [16:0] sum_wide;
	logic [15:0] sum_nxt;
	logic [15:0] ip_len_nxt;
	logic [15:0] ident_nxt;
	logic [15:0] flags_nxt;
	logic [7:0]  ttl_nxt;
	logic [31:0] dst_nxt;
	logic [15:0] payload;
	logic [16:0] len_wide;
	logic [15:0] len_sat;
	logic        is_frag;
	verdict_t    verdict;
	action_t     action;
	logic [15:0] running_len_nxt;
	logic [15:0] expected_id_nxt;
	logic [15:0] dlen;

	// only a last word needs the result register to be free
	assign advance_s1 = !last_s1 || !m_valid_q || m_axis_tready;
	assign fire_s1 = valid_s1 && advance_s1;
	assign s_axis_tready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			word_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= OWN_ADDR_RESET;
		end else if (own_address_we) begin
			own_addr_q <= own_address_wdata;
		end
	end

	always_comb begin
		sum_wide = {1'b0, ones_sum_q} + {1'b0, word_s1};
		// end-around carry
		sum_nxt = sum_wide[15:0] + {15'd0, sum_wide[16]};

		ip_len_nxt = ip_len_q;
		ident_nxt = ident_q;
		flags_nxt = flags_q;
		ttl_nxt = ttl_q;
		dst_nxt = dst_q;
		unique case (word_idx_q)
			POS_IP_LEN:    ip_len_nxt = word_s1;
			POS_ID:        ident_nxt = word_s1;
			POS_FLAGS:     flags_nxt = word_s1;
			POS_TTL:       ttl_nxt = word_s1[15:8];
			POS_DST_HI:    dst_nxt = {word_s1, dst_q[15:0]};
			POS_DST_LO:    dst_nxt = {dst_q[31:16], word_s1};
			default:       ;
		endcase

		payload = (ip_len_nxt >= HEADER_BYTES) ? (ip_len_nxt - HEADER_BYTES) : 16'd0;
		len_wide = {1'b0, running_len_q} + {1'b0, payload};
		len_sat = len_wide[16] ? 16'hFFFF : len_wide[15:0];

		priority if (dst_nxt != BROADCAST_ADDR && dst_nxt != own_addr_q) begin
			verdict = VERDICT_BAD_DST;
		end else if (sum_nxt != SUM_ALL_ONES && sum_nxt != SUM_ZERO) begin
			verdict = VERDICT_BAD_SUM;
		end else if (ttl_nxt == 8'd0) begin
			verdict = VERDICT_TTL_ZERO;
		end else begin
			verdict = VERDICT_OK;
		end

		is_frag = flags_nxt[MORE_FRAG_BIT] && (ident_nxt == expected_id_q);
		running_len_nxt = running_len_q;
		expected_id_nxt = expected_id_q;
		priority if (verdict != VERDICT_OK) begin
			action = ACTION_DROP;
			dlen = running_len_q;
		end else if (is_frag) begin
			action = ACTION_APPEND;
			running_len_nxt = len_sat;
			dlen = len_sat;
		end else begin
			action = ACTION_DELIVER;
			dlen = len_sat;
			running_len_nxt = 16'd0;
			expected_id_nxt = expected_id_q + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_idx_q <= '0;
			ones_sum_q <= '0;
			ip_len_q <= '0;
			ident_q <= '0;
			flags_q <= '0;
			ttl_q <= '0;
			dst_q <= '0;
			expected_id_q <= '0;
			running_len_q <= '0;
		end else if (fire_s1) begin
			if (last_s1) begin
				word_idx_q <= '0;
				ones_sum_q <= '0;
				ip_len_q <= '0;
				ident_q <= '0;
				flags_q <= '0;
				ttl_q <= '0;
				dst_q <= '0;
				expected_id_q <= expected_id_nxt;
				running_len_q <= running_len_nxt;
			end else begin
				if (word_idx_q != POS_MAX) begin
					word_idx_q <= word_idx_q + 4'd1;
				end
				ones_sum_q <= sum_nxt;
				ip_len_q <= ip_len_nxt;
				ident_q <= ident_nxt;
				flags_q <= flags_nxt;
				ttl_q <= ttl_nxt;
				dst_q <= dst_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			m_user_q.verdict <= verdict;
			m_user_q.action <= action;
			m_data_q.payload_length <= payload;
			m_data_q.datagram_length <= dlen;
			m_data_q.datagram_id <= expected_id_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser = m_user_q;
	assign m_axis_tdata = m_data_q;

`ifndef SYNTHESIS
	a_drop_matches_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> ((m_user_q.verdict == VERDICT_OK) == (m_user_q.action != ACTION_DROP)))
		else $error("action disagrees with verdict");

	a_header_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && last_s1) |=> (word_idx_q == 4'd0 && ones_sum_q == 16'd0 && dst_q == 32'd0))
		else $error("header state not cleared after last word");

	a_index_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && !last_s1) |=> (word_idx_q != 4'd0))
		else $error("word index did not advance");

	a_payload_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (m_data_q.payload_length <= (16'hFFFF - HEADER_BYTES)))
		else $error("payload length out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && last_s1) |-> (!m_valid_q || m_axis_tready))
		else $error("result register overwritten while stalled");
`endif

endmodule
